// File: hw/rtl/pvm_pkg.sv
// Shared types and constants for the paged byte memory with a page valid map.
// Used by every module of the block; depends on nothing else.

package pvm_pkg;

    // Default geometry; the top level hands these down as parameters.
    localparam int ADDR_BITS_DEF = 16;
    localparam int PAGE_BITS_DEF = 12;

    // Largest access moved by one read or write item.
    localparam int MAX_ACCESS_BYTES = 4;

    // Item field widths.
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 17;
    localparam int DATA_W  = 32;
    localparam int MASK_W  = 4;
    localparam int BYTE_W  = 8;

    // Width that holds any address sum and the memory size itself.
    localparam int EXT_W = 33;

    // Byte counter holds 0 to MAX_ACCESS_BYTES; the lane index selects one byte.
    localparam int KCNT_W = 3;
    localparam int LANE_W = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int RESULT_W  = DATA_W + MASK_W + 1;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_READ  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd4;

    // One result item, read_data in the lowest bits.
    typedef struct packed {
        logic              range_allocated;
        logic [MASK_W-1:0] byte_present;
        logic [DATA_W-1:0] read_data;
    } result_t;

    // Update of the page valid map for the page under the cursor.
    typedef struct packed {
        logic set;
        logic clear;
    } map_cmd_t;

endpackage

// File: hw/rtl/pvm_byte_ram.sv
// Byte-wide single-port store of the emulated memory, registered read data.
// Depends on pvm_pkg for the byte width.

module pvm_byte_ram #(
    parameter int ADDR_BITS = pvm_pkg::ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic [ADDR_BITS-1:0]      addr,
    input  logic                      we,
    input  logic [pvm_pkg::BYTE_W-1:0] wdata,
    output logic [pvm_pkg::BYTE_W-1:0] q
);

    localparam longint DEPTH = longint'(1) << ADDR_BITS;

    logic [pvm_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [pvm_pkg::BYTE_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        q_reg <= mem[addr];
    end

    assign q = q_reg;

endmodule

// File: hw/rtl/pvm_page_map.sv
// One valid bit per page, all cleared at reset, looked up at one page index.
// Depends on pvm_pkg for the map command struct.

module pvm_page_map #(
    parameter int ADDR_BITS = pvm_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BITS = pvm_pkg::PAGE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ADDR_BITS-PAGE_BITS-1:0] index,
    input  pvm_pkg::map_cmd_t            cmd,
    output logic                         valid
);

    localparam int PGW    = ADDR_BITS - PAGE_BITS;
    localparam int NPAGES = 1 << PGW;

    logic [NPAGES-1:0] valid_reg;
    logic [NPAGES-1:0] valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (cmd.set) begin
            valid_next[index] = 1'b1;
        end else if (cmd.clear) begin
            valid_next[index] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg[index];

endmodule

// File: hw/rtl/pvm_seq.sv
// Sequencer of the paged memory: one shared cursor adder steps through bytes
// and pages for every operation. Depends on pvm_pkg, drives the byte store
// and the page valid map.

module pvm_seq #(
    parameter int ADDR_BITS = pvm_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BITS = pvm_pkg::PAGE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input item
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pvm_pkg::OP_W-1:0]       op,
    input  logic [pvm_pkg::ADDR_W-1:0]     address,
    input  logic [pvm_pkg::COUNT_W-1:0]    byte_count,
    input  logic [pvm_pkg::DATA_W-1:0]     write_data,
    // Result item
    output logic                           res_valid,
    input  logic                           res_ready,
    output pvm_pkg::result_t               result,
    // Byte store
    output logic [ADDR_BITS-1:0]           ram_addr,
    output logic                           ram_we,
    output logic [pvm_pkg::BYTE_W-1:0]     ram_wdata,
    input  logic [pvm_pkg::BYTE_W-1:0]     ram_q,
    // Page valid map
    output logic [ADDR_BITS-PAGE_BITS-1:0] map_index,
    output pvm_pkg::map_cmd_t              map_cmd,
    input  logic                           map_valid
);

    localparam int PGW = ADDR_BITS - PAGE_BITS;
    localparam int XW  = pvm_pkg::EXT_W;
    localparam int SW  = ADDR_BITS + 1;
    localparam int KW  = pvm_pkg::KCNT_W;
    localparam int LW  = pvm_pkg::LANE_W;
    localparam logic [XW-1:0] MEM_SIZE  = XW'(1) << ADDR_BITS;
    localparam logic [SW-1:0] PAGE_STEP = SW'(1) << PAGE_BITS;
    localparam logic [SW-1:0] BYTE_STEP = SW'(1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SETUP  = 6'b000010,
        ST_ACCESS = 6'b000100,
        ST_PAGE   = 6'b001000,
        ST_ZERO   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [pvm_pkg::OP_W-1:0]    op_reg, op_next;
    logic [pvm_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [pvm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [pvm_pkg::DATA_W-1:0]  wdata_reg, wdata_next;
    logic [ADDR_BITS-1:0]        cur_reg, cur_next;
    logic [PGW-1:0]              last_pg_reg, last_pg_next;
    logic [KW-1:0]               len_reg, len_next;
    logic [KW-1:0]               kcnt_reg, kcnt_next;
    logic                        past_top_reg, past_top_next;
    logic                        cap_en_reg, cap_en_next;
    logic [LW-1:0]               cap_lane_reg, cap_lane_next;
    logic [pvm_pkg::DATA_W-1:0]  rdata_reg, rdata_next;
    logic [pvm_pkg::MASK_W-1:0]  present_reg, present_next;
    logic                        alloc_reg, alloc_next;

    logic [XW-1:0]   addr_x;
    logic [XW-1:0]   count_x;
    logic [XW-1:0]   end_x;
    logic            range_ok;
    logic            is_rw;
    logic [KW-1:0]   len_rw;
    logic [SW-1:0]   inc;
    logic [SW-1:0]   sum;
    logic [LW-1:0]   lane;
    logic            active;
    logic            last_page;
    logic            last_byte;

    // Range decode on the captured item.
    assign addr_x   = XW'(addr_reg);
    assign count_x  = XW'(count_reg);
    assign end_x    = addr_x + count_x - XW'(1);
    assign range_ok = (count_reg != '0) && (end_x < MEM_SIZE);
    assign is_rw    = (op_reg == pvm_pkg::OP_READ) || (op_reg == pvm_pkg::OP_WRITE);
    assign len_rw   = (count_reg > pvm_pkg::COUNT_W'(pvm_pkg::MAX_ACCESS_BYTES))
                      ? KW'(pvm_pkg::MAX_ACCESS_BYTES) : count_reg[KW-1:0];

    // The shared cursor adder: one byte a step, or one page while walking pages.
    assign inc = (state_reg == ST_PAGE) ? PAGE_STEP : BYTE_STEP;
    assign sum = {1'b0, cur_reg} + inc;

    assign lane      = kcnt_reg[LW-1:0];
    assign active    = (kcnt_reg < len_reg) && !past_top_reg;
    assign map_index = cur_reg[ADDR_BITS-1:PAGE_BITS];
    assign last_page = (map_index == last_pg_reg);
    assign last_byte = &cur_reg[PAGE_BITS-1:0];
    assign ram_addr  = cur_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        wdata_next    = wdata_reg;
        cur_next      = cur_reg;
        last_pg_next  = last_pg_reg;
        len_next      = len_reg;
        kcnt_next     = kcnt_reg;
        past_top_next = past_top_reg;
        cap_en_next   = 1'b0;
        cap_lane_next = cap_lane_reg;
        rdata_next    = rdata_reg;
        present_next  = present_reg;
        alloc_next    = alloc_reg;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        map_cmd       = '0;

        // Read data of the byte issued in the previous cycle lands here.
        if (cap_en_reg) begin
            rdata_next[{cap_lane_reg, 3'b000} +: pvm_pkg::BYTE_W] = ram_q;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = op;
                    addr_next  = address;
                    count_next = byte_count;
                    wdata_next = write_data;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                rdata_next    = '0;
                present_next  = '0;
                alloc_next    = 1'b0;
                kcnt_next     = '0;
                len_next      = len_rw;
                last_pg_next  = end_x[ADDR_BITS-1:PAGE_BITS];
                past_top_next = (addr_x >= MEM_SIZE);
                if (is_rw) begin
                    cur_next   = addr_x[ADDR_BITS-1:0];
                    state_next = ST_ACCESS;
                end else begin
                    cur_next = {addr_x[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
                    if (op_reg == pvm_pkg::OP_ALLOC || op_reg == pvm_pkg::OP_FREE) begin
                        state_next = range_ok ? ST_PAGE : ST_DONE;
                    end else if (op_reg == pvm_pkg::OP_CHECK) begin
                        // An empty range counts as allocated.
                        alloc_next = (count_reg == '0) || range_ok;
                        state_next = (count_reg != '0 && range_ok) ? ST_PAGE : ST_DONE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACCESS: begin
                if (active) begin
                    present_next[lane] = map_valid;
                    ram_we    = (op_reg == pvm_pkg::OP_WRITE) && map_valid;
                    ram_wdata = wdata_reg[{lane, 3'b000} +: pvm_pkg::BYTE_W];
                    cap_en_next   = (op_reg == pvm_pkg::OP_READ) && map_valid;
                    cap_lane_next = lane;
                    kcnt_next     = kcnt_reg + KW'(1);
                    cur_next      = sum[ADDR_BITS-1:0];
                    // A carry out of the cursor means the access ran past the top.
                    past_top_next = sum[ADDR_BITS];
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PAGE: begin
                cur_next = sum[ADDR_BITS-1:0];
                case (op_reg)
                    pvm_pkg::OP_ALLOC: begin
                        // A page that was not allocated is zeroed before it becomes valid.
                        if (!map_valid) begin
                            cur_next   = cur_reg;
                            state_next = ST_ZERO;
                        end else if (last_page) begin
                            state_next = ST_DONE;
                        end
                    end
                    pvm_pkg::OP_FREE: begin
                        map_cmd.clear = 1'b1;
                        if (last_page) begin
                            state_next = ST_DONE;
                        end
                    end
                    pvm_pkg::OP_CHECK: begin
                        if (!map_valid) begin
                            alloc_next = 1'b0;
                            state_next = ST_DONE;
                        end else if (last_page) begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_ZERO: begin
                ram_we   = 1'b1;
                cur_next = sum[ADDR_BITS-1:0];
                if (last_byte) begin
                    map_cmd.set = 1'b1;
                    state_next  = last_page ? ST_DONE : ST_PAGE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cap_en_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cap_en_reg <= cap_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        count_reg    <= count_next;
        wdata_reg    <= wdata_next;
        cur_reg      <= cur_next;
        last_pg_reg  <= last_pg_next;
        len_reg      <= len_next;
        kcnt_reg     <= kcnt_next;
        past_top_reg <= past_top_next;
        cap_lane_reg <= cap_lane_next;
        rdata_reg    <= rdata_next;
        present_reg  <= present_next;
        alloc_reg    <= alloc_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign result.read_data       = rdata_reg;
    assign result.byte_present    = present_reg;
    assign result.range_allocated = alloc_reg;

endmodule

// File: hw/rtl/paged_memory_with_valid_map.sv
// Paged byte memory with one valid bit per page. One item at a time: a read or
// write moves its bytes one at a time, and the next item is taken once its result is passed on.
// Range operations walk the pages one by one through the shared cursor adder, and an
// allocate zeroes each page that was free, byte by byte, before it marks it valid.
// Synchronous reset clears the page map and the control state; the byte store is
// not cleared, since a page is zeroed when it is allocated.

module paged_memory_with_valid_map #(
    parameter int ADDR_BITS = pvm_pkg::ADDR_BITS_DEF,
    parameter int PAGE_BITS = pvm_pkg::PAGE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // address[15:0], byte_count[32:16], write_data[64:33], zero padding
    input  logic [pvm_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[2:0]
    input  logic [pvm_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data[31:0], byte_present[35:32], range_allocated[36], zero padding
    output logic [pvm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int PGW = ADDR_BITS - PAGE_BITS;

    logic                           res_valid;
    logic                           res_ready;
    pvm_pkg::result_t               result;
    logic [ADDR_BITS-1:0]           ram_addr;
    logic                           ram_we;
    logic [pvm_pkg::BYTE_W-1:0]     ram_wdata;
    logic [pvm_pkg::BYTE_W-1:0]     ram_q;
    logic [PGW-1:0]                 map_index;
    pvm_pkg::map_cmd_t              map_cmd;
    logic                           map_valid;

    pvm_pkg::result_t               out_reg, out_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    pvm_byte_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .q     (ram_q)
    );

    pvm_page_map #(
        .ADDR_BITS (ADDR_BITS),
        .PAGE_BITS (PAGE_BITS)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .index   (map_index),
        .cmd     (map_cmd),
        .valid   (map_valid)
    );

    pvm_seq #(
        .ADDR_BITS (ADDR_BITS),
        .PAGE_BITS (PAGE_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .address    (s_tdata[15:0]),
        .byte_count (s_tdata[32:16]),
        .write_data (s_tdata[64:33]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result),
        .ram_addr   (ram_addr),
        .ram_we     (ram_we),
        .ram_wdata  (ram_wdata),
        .ram_q      (ram_q),
        .map_index  (map_index),
        .map_cmd    (map_cmd),
        .map_valid  (map_valid)
    );

    // The output register frees the sequencer while a result waits downstream.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            out_next      = result;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pvm_pkg::M_TDATA_W - pvm_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

// File: hw/rtl/pvm_checker.sv
// Port-level checks of the paged memory, attached to the top level by bind.
// Depends on pvm_pkg for the stream widths.

module pvm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pvm_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The block works on one item at a time, so it is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again in the cycle after an accept");

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state after reset is wrong");

    // Read bytes come only with a present mask, and never with a range result.
    a_result_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> (m_tdata[35:32] != 4'd0) && !m_tdata[36])
        else $error("read data without present bytes or mixed with a range result");

    // A range result never carries a byte mask.
    a_range_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> (m_tdata[35:32] == 4'd0))
        else $error("range result mixed with a byte mask");

endmodule

bind paged_memory_with_valid_map pvm_checker u_pvm_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for paged_memory_with_valid_map.
// Holds a shadow of the page valid map and the byte store to work out each response.
// Depends on pvm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;

    localparam int MEM_BYTES    = 1 << pvm_pkg::ADDR_W;
    localparam int PAGE_SHIFT   = pvm_pkg::PAGE_BITS_DEF;
    localparam int PAGE_COUNT   = MEM_BYTES >> PAGE_SHIFT;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 16;
    // Allocations that have to zero free pages dominate the run time.
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam logic [pvm_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [pvm_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct {
        logic [pvm_pkg::OP_W-1:0]    op;
        logic [pvm_pkg::ADDR_W-1:0]  addr;
        logic [pvm_pkg::COUNT_W-1:0] count;
        logic [pvm_pkg::DATA_W-1:0]  wdata;
        bit                          fixed;
        pvm_pkg::result_t            fixed_resp;
    } mem_request_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pvm_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [pvm_pkg::OP_W-1:0]        s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pvm_pkg::M_TDATA_W-1:0]   m_tdata;

    bit                              shadow_valid [PAGE_COUNT];
    bit [pvm_pkg::BYTE_W-1:0]        shadow_bytes [MEM_BYTES];
    pvm_pkg::result_t                owed_responses [$];
    mem_request_t                    directed_requests [$];
    logic [pvm_pkg::ADDR_W-1:0]      recent_writes [$];

    int                              mismatch_count = 0;
    int                              cycle_count = 0;
    int                              burst_left = 0;
    int                              stall_mode = 0;
    int                              stall_left = 0;
    int                              stall_tick = 0;
    pvm_pkg::result_t                seen_resp;
    pvm_pkg::result_t                owed_resp;

    paged_memory_with_valid_map u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Applies one item to the shadow memory and returns the response it owes.
    function automatic pvm_pkg::result_t shadow_access(
            input logic [pvm_pkg::OP_W-1:0] op,
            input logic [pvm_pkg::ADDR_W-1:0] addr,
            input logic [pvm_pkg::COUNT_W-1:0] count,
            input logic [pvm_pkg::DATA_W-1:0] wdata);
        pvm_pkg::result_t resp;
        int      n;
        int      a;
        int      k;
        int      pg;
        int      last_byte;
        resp = '0;
        last_byte = int'(addr) + int'(count) - 1;
        case (op)
            pvm_pkg::OP_READ, pvm_pkg::OP_WRITE: begin
                n = (count > pvm_pkg::MAX_ACCESS_BYTES) ? pvm_pkg::MAX_ACCESS_BYTES
                                                        : int'(count);
                if (n > MEM_BYTES - int'(addr))
                    n = MEM_BYTES - int'(addr);
                for (k = 0; k < n; k++) begin
                    a = int'(addr) + k;
                    if (shadow_valid[a >> PAGE_SHIFT]) begin
                        resp.byte_present[k] = 1'b1;
                        if (op == pvm_pkg::OP_READ)
                            resp.read_data[8*k +: 8] = shadow_bytes[a];
                        else
                            shadow_bytes[a] = wdata[8*k +: 8];
                    end
                end
            end
            pvm_pkg::OP_ALLOC, pvm_pkg::OP_FREE: begin
                if (count != 0 && last_byte < MEM_BYTES) begin
                    for (pg = int'(addr) >> PAGE_SHIFT; pg <= (last_byte >> PAGE_SHIFT); pg++) begin
                        if (op == pvm_pkg::OP_ALLOC) begin
                            shadow_valid[pg] = 1'b1;
                        end else begin
                            // A freed page must read as zero once allocated again.
                            shadow_valid[pg] = 1'b0;
                            for (a = pg << PAGE_SHIFT; a < ((pg + 1) << PAGE_SHIFT); a++)
                                shadow_bytes[a] = '0;
                        end
                    end
                end
            end
            pvm_pkg::OP_CHECK: begin
                if (count == 0) begin
                    resp.range_allocated = 1'b1;
                end else if (last_byte < MEM_BYTES) begin
                    resp.range_allocated = 1'b1;
                    for (pg = int'(addr) >> PAGE_SHIFT; pg <= (last_byte >> PAGE_SHIFT); pg++)
                        if (!shadow_valid[pg])
                            resp.range_allocated = 1'b0;
                end
            end
            default: ;
        endcase
        return resp;
    endfunction

    function automatic void add_request(input logic [pvm_pkg::OP_W-1:0] op,
                                        input logic [pvm_pkg::ADDR_W-1:0] addr,
                                        input logic [pvm_pkg::COUNT_W-1:0] count,
                                        input logic [pvm_pkg::DATA_W-1:0] wdata,
                                        input bit fixed,
                                        input logic [pvm_pkg::DATA_W-1:0] rdata,
                                        input logic [pvm_pkg::MASK_W-1:0] present,
                                        input logic alloc);
        mem_request_t req;
        req.op = op;
        req.addr = addr;
        req.count = count;
        req.wdata = wdata;
        req.fixed = fixed;
        req.fixed_resp.read_data = rdata;
        req.fixed_resp.byte_present = present;
        req.fixed_resp.range_allocated = alloc;
        directed_requests.push_back(req);
    endfunction

    // Presents one item, holds it until taken, and records the response it owes.
    task automatic send_request(input mem_request_t req);
        int               gap;
        pvm_pkg::result_t resp;
        if (burst_left == 0) begin
            gap = int'($urandom_range(0, 6));
            burst_left = int'($urandom_range(1, 40));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {7'b0, req.wdata, req.count, req.addr};
        do @(negedge aclk); while (!s_tready);
        resp = shadow_access(req.op, req.addr, req.count, req.wdata);
        owed_responses.push_back(req.fixed ? req.fixed_resp : resp);
        @(posedge aclk);
    endtask

    // The receiver switches between always ready, random stalls and a slow
    // one-in-eight pattern.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= int'($urandom_range(0, 2));
            stall_left <= int'($urandom_range(64, 256));
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (stall_tick % 8 == 0);
        endcase
    end

    // Signals are stable at the falling edge, so a handshake seen here takes
    // place at the next rising edge.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_resp = pvm_pkg::result_t'(m_tdata[pvm_pkg::RESULT_W-1:0]);
            if (owed_responses.size() == 0) begin
                $display("%0t: response with none outstanding: %h", $realtime, m_tdata);
                mismatch_count++;
            end else begin
                owed_resp = owed_responses.pop_front();
                if (seen_resp.read_data !== owed_resp.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $realtime,
                             owed_resp.read_data, seen_resp.read_data);
                    mismatch_count++;
                end
                if (seen_resp.byte_present !== owed_resp.byte_present) begin
                    $display("%0t: byte_present expected %h actual %h", $realtime,
                             owed_resp.byte_present, seen_resp.byte_present);
                    mismatch_count++;
                end
                if (seen_resp.range_allocated !== owed_resp.range_allocated) begin
                    $display("%0t: range_allocated expected %b actual %b", $realtime,
                             owed_resp.range_allocated, seen_resp.range_allocated);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        mem_request_t                req;
        logic [pvm_pkg::OP_W-1:0]    op;
        logic [pvm_pkg::ADDR_W-1:0]  addr;
        logic [pvm_pkg::COUNT_W-1:0] count;
        int                          sel;
        int                          random_done;

        // Untouched memory, extremes of the fields and the clipping cases.
        add_request(pvm_pkg::OP_READ,  16'h0000, 17'd4,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_CHECK, 16'h0000, 17'd0,     32'h0,        1, 32'h0, 4'h0, 1'b1);
        add_request(pvm_pkg::OP_CHECK, 16'h1234, 17'd1,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_WRITE, 16'h0010, 17'd4,     32'hFFFFFFFF, 1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_CHECK, 16'hFFFF, 17'd2,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_ALLOC, 16'h0000, 17'h10000, 32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_CHECK, 16'h0000, 17'h10000, 32'h0,        1, 32'h0, 4'h0, 1'b1);
        add_request(pvm_pkg::OP_WRITE, 16'hFFFE, 17'd4,     32'hAABBCCDD, 1, 32'h0, 4'h3, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'hFFFC, 17'd5,     32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'hFFFF, 17'h10000, 32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_WRITE, 16'h0FFE, 17'd4,     32'h12345678, 0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'h0FFE, 17'd3,     32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_WRITE, 16'h0000, 17'd0,     32'hFFFFFFFF, 1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_FREE,  16'h1000, 17'd1,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'h0FFE, 17'd4,     32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_CHECK, 16'h0800, 17'h01000, 32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_ALLOC, 16'h1FFF, 17'd1,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'h1000, 17'd2,     32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_ALLOC, 16'h0000, 17'd1,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_READ,  16'h0FFC, 17'd4,     32'h0,        0, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_FREE,  16'hF000, 17'h02000, 32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_FREE,  16'h3000, 17'd0,     32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_FREE,  16'h2000, 17'h01000, 32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_FREE,  16'h2000, 17'h01000, 32'h0,        1, 32'h0, 4'h0, 1'b0);
        add_request(OP_RSVD_FIRST, 16'hFFFF, 17'h10000, 32'hFFFFFFFF, 1, 32'h0, 4'h0, 1'b0);
        add_request(OP_RSVD_LAST,  16'h0000, 17'd1,     32'h5A5A5A5A, 1, 32'h0, 4'h0, 1'b0);
        add_request(pvm_pkg::OP_CHECK, 16'hFFFF, 17'd1,     32'h0,        1, 32'h0, 4'h0, 1'b1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_requests[i])
            send_request(directed_requests[i]);

        random_done = 0;
        req.fixed = 1'b0;
        req.fixed_resp = '0;
        while (random_done < RANDOM_ITEMS) begin
            sel = int'($urandom_range(0, 99));
            if (sel < 40)      op = pvm_pkg::OP_READ;
            else if (sel < 72) op = pvm_pkg::OP_WRITE;
            else if (sel < 75) op = pvm_pkg::OP_ALLOC;
            else if (sel < 78) op = pvm_pkg::OP_FREE;
            else if (sel < 98) op = pvm_pkg::OP_CHECK;
            else               op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            sel = int'($urandom_range(0, 99));
            case (op)
                pvm_pkg::OP_ALLOC: begin
                    // Allocations stay at one or two pages to bound the zeroing time.
                    if (sel < 10) begin
                        addr = 16'($urandom);
                        count = '0;
                    end else if (sel < 20) begin
                        addr = 16'hE000 + 16'($urandom_range(0, 16'h1FFF));
                        count = 17'($urandom_range(17'h02001, 17'h10000));
                    end else begin
                        addr = 16'(($urandom_range(0, PAGE_COUNT - 1) << PAGE_SHIFT)
                                   + $urandom_range(0, 4095));
                        count = 17'($urandom_range(1, 4096));
                    end
                end
                pvm_pkg::OP_FREE: begin
                    addr = 16'($urandom);
                    count = 17'((sel < 70) ? $urandom_range(1, 4096)
                                           : $urandom_range(0, 65536));
                end
                pvm_pkg::OP_CHECK: begin
                    addr = 16'($urandom);
                    if (sel < 10)      count = '0;
                    else if (sel < 50) count = 17'($urandom_range(1, 4096));
                    else if (sel < 90) count = 17'($urandom_range(0, 65536));
                    else               count = 17'h10000;
                end
                default: begin
                    if (recent_writes.size() != 0 && sel < 45)
                        addr = 16'(recent_writes[$urandom_range(0, recent_writes.size() - 1)]
                                   + $urandom_range(0, 6) - 3);
                    else if (sel < 65)
                        addr = 16'(($urandom_range(0, PAGE_COUNT - 1) << PAGE_SHIFT)
                                   + $urandom_range(0, 7) - 4);
                    else if (sel < 75)
                        addr = 16'hFFFF - 16'($urandom_range(0, 7));
                    else
                        addr = 16'($urandom);
                    sel = int'($urandom_range(0, 99));
                    if (sel < 5)       count = '0;
                    else if (sel < 85) count = 17'($urandom_range(1, pvm_pkg::MAX_ACCESS_BYTES));
                    else if (sel < 95) count = 17'($urandom_range(5, 65536));
                    else               count = 17'h10000;
                end
            endcase
            req.op = op;
            req.addr = addr;
            req.count = count;
            req.wdata = $urandom;
            send_request(req);
            if (op == pvm_pkg::OP_WRITE) begin
                recent_writes.push_back(addr);
                if (recent_writes.size() > 32)
                    void'(recent_writes.pop_front());
            end
            if (op <= pvm_pkg::OP_CHECK)
                random_done++;
        end
        s_tvalid <= 1'b0;

        while (owed_responses.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/pvm_pkg.sv
hw/rtl/pvm_byte_ram.sv
hw/rtl/pvm_page_map.sv
hw/rtl/pvm_seq.sv
hw/rtl/paged_memory_with_valid_map.sv
hw/rtl/pvm_checker.sv
dv/tb_top.sv
